// ===== sv/aluw_pkg.sv =====
// ----------------------------------------------------------------------------
// aluw_pkg
// Shared types, opcodes and flag constants for the byte and word add unit.
// ----------------------------------------------------------------------------
package aluw_pkg;

  // decoded operation codes
  localparam logic [2:0] OP_AND  = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_ADC  = 3'd2;
  localparam logic [2:0] OP_ADIW = 3'd3;
  localparam logic [2:0] OP_BAD  = 3'd4;

  // instruction opcode fields
  localparam logic [5:0] OPC_ADD  = 6'h03;
  localparam logic [5:0] OPC_ADC  = 6'h07;
  localparam logic [5:0] OPC_AND  = 6'h08;
  localparam logic [7:0] OPC_ADIW = 8'h96;

  // status bits kept by each instruction class
  localparam logic [7:0] KEEP_ADD  = 8'hC0;
  localparam logic [7:0] KEEP_AND  = 8'hE1;
  localparam logic [7:0] KEEP_WORD = 8'hE0;

  // first register of the word pairs
  localparam logic [4:0] PAIR_BASE = 5'd24;

  // status register bit positions
  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_N = 2;
  localparam int FLAG_V = 3;
  localparam int FLAG_S = 4;
  localparam int FLAG_H = 5;

  // decoded instruction handed from front to back
  typedef struct packed {
    logic [2:0] op;
    logic [4:0] ra;
    logic [4:0] rb;
    logic [4:0] dst;
    logic [5:0] k;
  } uop_t;

  // register file read request
  typedef struct packed {
    logic       re;
    logic [4:0] ra;
    logic [4:0] rb;
  } rf_rd_t;

  // register file write, one port per bank
  typedef struct packed {
    logic       we_even;
    logic       we_odd;
    logic [3:0] addr_even;
    logic [3:0] addr_odd;
    logic [7:0] data_even;
    logic [7:0] data_odd;
  } rf_wr_t;

endpackage

// ===== sv/eight_bit_alu_add_and_word_add_unit.sv =====
// ----------------------------------------------------------------------------
// eight_bit_alu_add_and_word_add_unit
// Byte add, add with carry, and, and word add on a 32 x 8 register file.
// ----------------------------------------------------------------------------
// a word passes holding register, queue, operand stage and result register in turn
// throughput: one word per cycle unless stalled, dependent words too (read bypass)
// the loop setting the rate is the execute and status update
// reset: clears the register file valid bits, status register, queue and all valids
// register file entries read as zero until written, so no clearing pass is needed
module eight_bit_alu_add_and_word_add_unit import aluw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        instr_valid,
  output logic        instr_stall,
  input  logic [15:0] instruction,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [4:0]  write_index,
  output logic [7:0]  write_value,
  output logic [7:0]  write_high_value,
  output logic        wrote_pair,
  output logic [7:0]  flags,
  output logic        status_code
);

  logic       q_full;
  logic       push;
  uop_t       push_data;
  logic       head_valid;
  uop_t       head_data;
  logic       pop;
  rf_rd_t     rf_rd;
  rf_wr_t     rf_wr;
  logic [7:0] rd_a;
  logic [7:0] rd_b;

  // decode
  aluw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .instr_valid (instr_valid),
    .instr_stall (instr_stall),
    .instruction (instruction),
    .q_full      (q_full),
    .push        (push),
    .push_data   (push_data)
  );

  // decoupling queue
  aluw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  // register file
  aluw_regfile u_regfile (
    .clk  (clk),
    .rst  (rst),
    .rd   (rf_rd),
    .wr   (rf_wr),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  // execute
  aluw_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head_valid       (head_valid),
    .head_data        (head_data),
    .pop              (pop),
    .rf_rd            (rf_rd),
    .rf_wr            (rf_wr),
    .rd_a             (rd_a),
    .rd_b             (rd_b),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .write_index      (write_index),
    .write_value      (write_value),
    .write_high_value (write_high_value),
    .wrote_pair       (wrote_pair),
    .flags            (flags),
    .status_code      (status_code)
  );

endmodule

// ===== sv/aluw_front.sv =====
// ----------------------------------------------------------------------------
// aluw_front
// Accepts instruction words and decodes them into operations for the queue.
// ----------------------------------------------------------------------------
module aluw_front import aluw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        instr_valid,
  output logic        instr_stall,
  input  logic [15:0] instruction,
  input  logic        q_full,
  output logic        push,
  output uop_t        push_data
);

  logic fv;
  uop_t fu;
  uop_t dec;
  logic take;
  logic [4:0] pair_lo;

  // decode
  always_comb begin
    pair_lo = PAIR_BASE + {2'b00, instruction[5:4], 1'b0};
    dec.ra  = instruction[8:4];
    dec.rb  = {instruction[9], instruction[3:0]};
    dec.dst = instruction[8:4];
    dec.k   = {instruction[7:6], instruction[3:0]};
    if (instruction[15:10] == OPC_AND) begin
      dec.op = OP_AND;
    end else if (instruction[15:10] == OPC_ADD) begin
      dec.op = OP_ADD;
    end else if (instruction[15:10] == OPC_ADC) begin
      dec.op = OP_ADC;
    end else if (instruction[15:8] == OPC_ADIW) begin
      dec.op  = OP_ADIW;
      dec.ra  = pair_lo;
      dec.rb  = pair_lo | 5'd1;
      dec.dst = pair_lo;
    end else begin
      dec.op = OP_BAD;
    end
  end

  // handshake
  assign instr_stall = fv && q_full;
  assign take        = instr_valid && !instr_stall;
  assign push        = fv && !q_full;
  assign push_data   = fu;

  // holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (take) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fu <= dec;
    end
  end

endmodule

// ===== sv/aluw_queue.sv =====
// ----------------------------------------------------------------------------
// aluw_queue
// Two-entry queue of decoded operations between front and back.
// ----------------------------------------------------------------------------
module aluw_queue import aluw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  uop_t push_data,
  output logic full,
  output logic head_valid,
  output uop_t head_data,
  input  logic pop
);

  uop_t       entries [2];
  logic [1:0] count;
  logic       wp;
  logic       rp;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head_data  = entries[rp];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= push_data;
    end
  end

  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst) pop |-> count != 2'd0)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");

endmodule

// ===== sv/aluw_regfile.sv =====
// ----------------------------------------------------------------------------
// aluw_regfile
// 32 x 8 register file in even and odd banks, registered reads with bypass.
// ----------------------------------------------------------------------------
module aluw_regfile import aluw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  rf_rd_t     rd,
  input  rf_wr_t     wr,
  output logic [7:0] rd_a,
  output logic [7:0] rd_b
);

  logic [7:0]  mem_even [16];
  logic [7:0]  mem_odd  [16];
  logic [15:0] vld_even;
  logic [15:0] vld_odd;
  logic [3:0]  ia;
  logic [3:0]  ib;
  logic [7:0]  ea;
  logic [7:0]  eb;
  logic [7:0]  oa;
  logic [7:0]  ob;
  logic        a_odd;
  logic        b_odd;

  assign ia = rd.ra[4:1];
  assign ib = rd.rb[4:1];

  // entry valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_even <= '0;
      vld_odd  <= '0;
    end else begin
      if (wr.we_even) begin
        vld_even[wr.addr_even] <= 1'b1;
      end
      if (wr.we_odd) begin
        vld_odd[wr.addr_odd] <= 1'b1;
      end
    end
  end

  // bank writes
  always_ff @(posedge clk) begin
    if (wr.we_even) begin
      mem_even[wr.addr_even] <= wr.data_even;
    end
    if (wr.we_odd) begin
      mem_odd[wr.addr_odd] <= wr.data_odd;
    end
  end

  // bank reads, a write in the same cycle is passed through
  always_ff @(posedge clk) begin
    if (rd.re) begin
      a_odd <= rd.ra[0];
      b_odd <= rd.rb[0];
      ea <= (wr.we_even && wr.addr_even == ia) ? wr.data_even :
            (vld_even[ia] ? mem_even[ia] : 8'h00);
      eb <= (wr.we_even && wr.addr_even == ib) ? wr.data_even :
            (vld_even[ib] ? mem_even[ib] : 8'h00);
      oa <= (wr.we_odd && wr.addr_odd == ia) ? wr.data_odd :
            (vld_odd[ia] ? mem_odd[ia] : 8'h00);
      ob <= (wr.we_odd && wr.addr_odd == ib) ? wr.data_odd :
            (vld_odd[ib] ? mem_odd[ib] : 8'h00);
    end
  end

  assign rd_a = a_odd ? oa : ea;
  assign rd_b = b_odd ? ob : eb;

endmodule

// ===== sv/aluw_back.sv =====
// ----------------------------------------------------------------------------
// aluw_back
// Operand stage, execute with status update, and the result register.
// ----------------------------------------------------------------------------
module aluw_back import aluw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  uop_t       head_data,
  output logic       pop,
  output rf_rd_t     rf_rd,
  output rf_wr_t     rf_wr,
  input  logic [7:0] rd_a,
  input  logic [7:0] rd_b,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [4:0] write_index,
  output logic [7:0] write_value,
  output logic [7:0] write_high_value,
  output logic       wrote_pair,
  output logic [7:0] flags,
  output logic       status_code
);

  logic       s2_valid;
  uop_t       s2;
  logic [7:0] sreg;
  logic       out_ready;
  logic       retire;

  logic       cin;
  logic [8:0] sum9;
  logic [7:0] rs;
  logic [7:0] andv;
  logic [15:0] word;
  logic [15:0] wsum;
  logic       c_b;
  logic       h_b;
  logic       v_b;
  logic       c_w;
  logic       v_w;
  logic [7:0] f_next;
  logic [4:0] widx;
  logic [7:0] wval;
  logic [7:0] whi;
  logic       wpair;
  logic       wcode;
  logic       wbyte;

  // stage control
  assign out_ready = !result_valid || !result_stall;
  assign retire    = s2_valid && out_ready;
  assign pop       = head_valid && (!s2_valid || out_ready);

  assign rf_rd.re = pop;
  assign rf_rd.ra = head_data.ra;
  assign rf_rd.rb = head_data.rb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (pop) begin
      s2_valid <= 1'b1;
    end else if (retire) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2 <= head_data;
    end
  end

  // byte and word arithmetic
  always_comb begin
    cin  = (s2.op == OP_ADC) ? sreg[FLAG_C] : 1'b0;
    sum9 = {1'b0, rd_a} + {1'b0, rd_b} + {8'h00, cin};
    rs   = sum9[7:0];
    andv = rd_a & rd_b;
    c_b  = (rd_a[7] & rd_b[7]) | (rd_b[7] & ~rs[7]) | (~rs[7] & rd_a[7]);
    h_b  = (rd_a[3] & rd_b[3]) | (rd_b[3] & ~rs[3]) | (~rs[3] & rd_a[3]);
    v_b  = (rd_a[7] & rd_b[7] & ~rs[7]) | (~rd_a[7] & ~rd_b[7] & rs[7]);
    word = {rd_b, rd_a};
    wsum = word + {10'd0, s2.k};
    c_w  = ~wsum[15] & word[15];
    v_w  = ~word[15] & wsum[15];
  end

  // result and status selection
  always_comb begin
    f_next = sreg;
    widx   = 5'd0;
    wval   = 8'h00;
    whi    = 8'h00;
    wpair  = 1'b0;
    wcode  = 1'b0;
    wbyte  = 1'b0;
    case (s2.op)
      OP_AND: begin
        f_next         = sreg & KEEP_AND;
        f_next[FLAG_Z] = andv == 8'h00;
        f_next[FLAG_N] = andv[7];
        f_next[FLAG_S] = andv[7];
        widx  = s2.dst;
        wval  = andv;
        wbyte = 1'b1;
      end
      OP_ADD, OP_ADC: begin
        f_next         = sreg & KEEP_ADD;
        f_next[FLAG_C] = c_b;
        f_next[FLAG_Z] = rs == 8'h00;
        f_next[FLAG_N] = rs[7];
        f_next[FLAG_V] = v_b;
        f_next[FLAG_S] = rs[7] ^ v_b;
        f_next[FLAG_H] = h_b;
        widx  = s2.dst;
        wval  = rs;
        wbyte = 1'b1;
      end
      OP_ADIW: begin
        f_next         = sreg & KEEP_WORD;
        f_next[FLAG_C] = c_w;
        f_next[FLAG_Z] = wsum == 16'h0000;
        f_next[FLAG_N] = wsum[15];
        f_next[FLAG_V] = v_w;
        f_next[FLAG_S] = wsum[15] ^ v_w;
        widx  = s2.dst;
        wval  = wsum[7:0];
        whi   = wsum[15:8];
        wpair = 1'b1;
      end
      default: begin
        wcode = 1'b1;
      end
    endcase
  end

  // register file write on retire
  always_comb begin
    rf_wr.we_even   = retire && (wpair || (wbyte && !widx[0]));
    rf_wr.we_odd    = retire && (wpair || (wbyte && widx[0]));
    rf_wr.addr_even = widx[4:1];
    rf_wr.addr_odd  = widx[4:1];
    rf_wr.data_even = wval;
    rf_wr.data_odd  = wpair ? whi : wval;
  end

  // status register
  always_ff @(posedge clk) begin
    if (rst) begin
      sreg <= 8'h00;
    end else if (retire) begin
      sreg <= f_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (retire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      write_index      <= widx;
      write_value      <= wval;
      write_high_value <= whi;
      wrote_pair       <= wpair;
      flags            <= f_next;
      status_code      <= wcode;
    end
  end

  a_pair_reg: assert property (@(posedge clk) disable iff (rst)
      (result_valid && wrote_pair) |-> (!write_index[0] && write_index[4:3] == 2'b11))
    else $error("word result names a bad register pair");
  a_bad_quiet: assert property (@(posedge clk) disable iff (rst)
      (result_valid && status_code) |-> (!wrote_pair && write_value == 8'h00 &&
                                         write_index == 5'd0))
    else $error("unknown opcode reported a write");

endmodule
